[sv/blhf_pkg.sv]
// Package for the button light hold-and-fade engine: payload types, codes and widths.
package blhf_pkg;

  // Field widths that follow from the item and register formats.
  localparam int MS_W    = 16;
  localparam int MASK_W  = 32;
  localparam int TIMER_W = 17;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 5;
  localparam int QBIT_W  = 3;   // Counts the quotient bits of one channel.
  localparam int ACC_W   = 24;  // Holds start*t + end*(F-t), never above 255*F.
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_MS     = 2'd0,
    REG_FADEOUT_MS  = 2'd1,
    REG_BUTTON_MASK = 2'd2,
    REG_ANIM_EN     = 2'd3
  } cfg_reg_e;

  // Item kinds.
  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_e;

  // Color channel being blended.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // Engine sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FRAME = 2'd1,
    ST_QUERY = 2'd2,
    ST_PUSH  = 2'd3
  } eng_state_e;

  // Blend unit states.
  typedef enum logic [1:0] {
    BL_IDLE  = 2'd0,
    BL_MUL_S = 2'd1,
    BL_MUL_E = 2'd2,
    BL_DIV   = 2'd3
  } blend_state_e;

  // Input transaction payload.
  typedef struct packed {
    item_kind_e          kind;
    logic [MASK_W-1:0]   pressed_mask;
    logic [MS_W-1:0]     elapsed_ms;
    logic [IDX_W-1:0]    light_index;
    logic [CHAN_W-1:0]   start_red;
    logic [CHAN_W-1:0]   start_green;
    logic [CHAN_W-1:0]   start_blue;
    logic [CHAN_W-1:0]   end_red;
    logic [CHAN_W-1:0]   end_green;
    logic [CHAN_W-1:0]   end_blue;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [MASK_W-1:0] new_press_mask;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } out_item_t;

  // Request from the sequencer to the blend unit.
  typedef struct packed {
    logic               start;
    logic [CHAN_W-1:0]  s;
    logic [CHAN_W-1:0]  e;
    logic [TIMER_W-1:0] t;
    logic [MS_W-1:0]    f;
  } blend_req_t;

  // Response from the blend unit.
  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] value;
  } blend_rsp_t;

endpackage

[sv/button_led_hold_fade_engine.sv]
// Top level of the button light hold-and-fade engine: timers, sequencer and output register.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   blhf_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i blhf_pkg::out_item_t
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A frame transaction walks the light timers one per cycle, or skips the walk
// when animation is disabled.
// A query transaction runs three channels through the blend unit, each passed straight through when
// the timer is zero or above the fade time and multiplied and divided otherwise.
// Reset clears all timers and loads the register reset values; the block is ready at once.
// A stalled result waits in the output register while the next transaction is accepted;
// a finished result that cannot enter the output register holds the sequencer.
module button_led_hold_fade_engine #(
  parameter int NUM_LIGHTS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  blhf_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output blhf_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [blhf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [blhf_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int IdxW = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;

  // Configuration registers.
  logic [blhf_pkg::MS_W-1:0]   hold_q, fade_q;
  logic [blhf_pkg::MASK_W-1:0] bmask_q;
  logic                        anim_q;

  // Sequencer and working registers.
  blhf_pkg::eng_state_e        state_q, state_d;
  blhf_pkg::in_item_t          item_q, item_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [blhf_pkg::MASK_W-1:0] news_q, news_d;
  blhf_pkg::chan_e             ch_q, ch_d;
  logic                        start_q, start_d;
  logic [blhf_pkg::TIMER_W-1:0] qt_q, qt_d;
  blhf_pkg::out_item_t         res_q, res_d;
  blhf_pkg::out_item_t         out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  // Light timers.
  logic [blhf_pkg::TIMER_W-1:0] timer_q [NUM_LIGHTS];
  logic                         timer_we;
  logic [blhf_pkg::TIMER_W-1:0] timer_wdata;

  logic                         in_acc;
  logic                         in_range;
  logic [blhf_pkg::TIMER_W-1:0] cur_t;
  logic [blhf_pkg::TIMER_W-1:0] elapsed_x;
  logic [blhf_pkg::TIMER_W-1:0] reload;

  blhf_pkg::blend_req_t         breq;
  blhf_pkg::blend_rsp_t         brsp;

  assign in_stall_o = (state_q != blhf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, in_data_i.light_index} < (blhf_pkg::IDX_W + 1)'(NUM_LIGHTS));
  assign cur_t      = timer_q[idx_q];
  assign elapsed_x  = blhf_pkg::TIMER_W'(item_q.elapsed_ms);
  assign reload     = blhf_pkg::TIMER_W'(hold_q) + blhf_pkg::TIMER_W'(fade_q);

  // Configuration writes; a zero hold time is stored as one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= blhf_pkg::MS_W'(1);
      fade_q  <= '0;
      bmask_q <= '0;
      anim_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (blhf_pkg::cfg_reg_e'(cfg_index_i))
        blhf_pkg::REG_HOLD_MS: begin
          hold_q <= (cfg_data_i[blhf_pkg::MS_W-1:0] == '0) ? blhf_pkg::MS_W'(1)
                                                          : cfg_data_i[blhf_pkg::MS_W-1:0];
        end
        blhf_pkg::REG_FADEOUT_MS: begin
          fade_q <= cfg_data_i[blhf_pkg::MS_W-1:0];
        end
        blhf_pkg::REG_BUTTON_MASK: begin
          bmask_q <= cfg_data_i[blhf_pkg::MASK_W-1:0];
        end
        blhf_pkg::REG_ANIM_EN: begin
          anim_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Blend request for the current channel.
  always_comb begin
    breq.start = start_q;
    breq.t     = qt_q;
    breq.f     = fade_q;
    case (ch_q)
      blhf_pkg::CH_RED: begin
        breq.s = item_q.start_red;
        breq.e = item_q.end_red;
      end
      blhf_pkg::CH_GREEN: begin
        breq.s = item_q.start_green;
        breq.e = item_q.end_green;
      end
      default: begin
        breq.s = item_q.start_blue;
        breq.e = item_q.end_blue;
      end
    endcase
  end

  blhf_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (breq),
    .rsp_o  (brsp)
  );

  // Sequencer: next state, timer update and result assembly.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    news_d      = news_q;
    ch_d        = ch_q;
    start_d     = 1'b0;
    qt_d        = qt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    timer_we    = 1'b0;
    timer_wdata = cur_t;

    // The output register empties when its transaction is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      blhf_pkg::ST_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          res_d  = '0;
          news_d = '0;
          idx_d  = '0;
          ch_d   = blhf_pkg::CH_RED;
          if (in_data_i.kind == blhf_pkg::KIND_QUERY) begin
            qt_d    = in_range ? timer_q[in_data_i.light_index[IdxW-1:0]] : '0;
            start_d = 1'b1;
            state_d = blhf_pkg::ST_QUERY;
          end else if (anim_q) begin
            state_d = blhf_pkg::ST_FRAME;
          end else begin
            state_d = blhf_pkg::ST_PUSH;
          end
        end
      end
      blhf_pkg::ST_FRAME: begin
        // One light per cycle: reload on press, otherwise count down to zero.
        if (bmask_q[idx_q]) begin
          if (item_q.pressed_mask[idx_q]) begin
            if (cur_t == '0) begin
              news_d[idx_q] = 1'b1;
            end
            timer_we    = 1'b1;
            timer_wdata = reload;
          end else if (cur_t != '0) begin
            timer_we    = 1'b1;
            timer_wdata = (cur_t > elapsed_x) ? (cur_t - elapsed_x) : '0;
          end
        end
        if (idx_q == IdxW'(NUM_LIGHTS - 1)) begin
          res_d.new_press_mask = news_d;
          state_d              = blhf_pkg::ST_PUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      blhf_pkg::ST_QUERY: begin
        if (brsp.done) begin
          case (ch_q)
            blhf_pkg::CH_RED: begin
              res_d.out_red = brsp.value;
              ch_d          = blhf_pkg::CH_GREEN;
              start_d       = 1'b1;
            end
            blhf_pkg::CH_GREEN: begin
              res_d.out_green = brsp.value;
              ch_d            = blhf_pkg::CH_BLUE;
              start_d         = 1'b1;
            end
            default: begin
              res_d.out_blue = brsp.value;
              state_d        = blhf_pkg::ST_PUSH;
            end
          endcase
        end
      end
      blhf_pkg::ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = blhf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blhf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blhf_pkg::ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    news_q <= news_d;
    ch_q   <= ch_d;
    qt_q   <= qt_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Light timers, cleared by reset and written one light at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        timer_q[i] <= '0;
      end
    end else if (timer_we) begin
      timer_q[idx_q] <= timer_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/blhf_blend.sv]
// Multi-cycle blend unit: one color channel through a shared multiplier and a restoring divider.
module blhf_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blhf_pkg::blend_req_t req_i,
  output blhf_pkg::blend_rsp_t rsp_o
);

  blhf_pkg::blend_state_e state_q, state_d;
  logic [blhf_pkg::CHAN_W-1:0] s_q, s_d, e_q, e_d;
  logic [blhf_pkg::MS_W-1:0]   t_q, t_d, f_q, f_d;
  logic [blhf_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [blhf_pkg::CHAN_W-1:0] quo_q, quo_d;
  logic [blhf_pkg::QBIT_W-1:0] bit_q, bit_d;
  logic                        done_q, done_d;

  logic [blhf_pkg::CHAN_W-1:0] mul_a;
  logic [blhf_pkg::MS_W-1:0]   mul_b;
  logic [blhf_pkg::ACC_W-1:0]  prod;
  logic [blhf_pkg::ACC_W-1:0]  dvs;

  // The one multiplier serves both weighted terms; the subtractor serves the divide.
  assign mul_a = (state_q == blhf_pkg::BL_MUL_S) ? s_q : e_q;
  assign mul_b = (state_q == blhf_pkg::BL_MUL_S) ? t_q : (f_q - t_q);
  assign prod  = blhf_pkg::ACC_W'(mul_a) * blhf_pkg::ACC_W'(mul_b);
  assign dvs   = blhf_pkg::ACC_W'(f_q) << bit_q;

  // Sequencer for one channel.
  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    e_d     = e_q;
    t_d     = t_q;
    f_d     = f_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    case (state_q)
      blhf_pkg::BL_IDLE: begin
        if (req_i.start) begin
          s_d   = req_i.s;
          e_d   = req_i.e;
          t_d   = req_i.t[blhf_pkg::MS_W-1:0];
          f_d   = req_i.f;
          bit_d = blhf_pkg::QBIT_W'(blhf_pkg::CHAN_W - 1);
          if (req_i.t == '0) begin
            // Timer run out: idle color.
            quo_d  = req_i.e;
            done_d = 1'b1;
          end else if (req_i.t > blhf_pkg::TIMER_W'(req_i.f)) begin
            // Still in the hold time: pressed color.
            quo_d  = req_i.s;
            done_d = 1'b1;
          end else begin
            quo_d   = '0;
            state_d = blhf_pkg::BL_MUL_S;
          end
        end
      end
      blhf_pkg::BL_MUL_S: begin
        acc_d   = prod;
        state_d = blhf_pkg::BL_MUL_E;
      end
      blhf_pkg::BL_MUL_E: begin
        acc_d   = acc_q + prod;
        state_d = blhf_pkg::BL_DIV;
      end
      blhf_pkg::BL_DIV: begin
        // One quotient bit per cycle, most significant first.
        if (acc_q >= dvs) begin
          acc_d        = acc_q - dvs;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == '0) begin
          done_d  = 1'b1;
          state_d = blhf_pkg::BL_IDLE;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      default: begin
        state_d = blhf_pkg::BL_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blhf_pkg::BL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    e_q   <= e_d;
    t_q   <= t_d;
    f_q   <= f_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = quo_q;

endmodule

[sv/blhf_checker.sv]
// Port-level checker for the hold-and-fade engine and its bind to the top level.
module blhf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input blhf_pkg::out_item_t            out_data_o
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed or dropped");

  // The engine is busy in the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("engine ready right after accepting a transaction");

  // A new result only appears at the end of work on a transaction.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in progress");

  // A frame result carries no color and a query result carries no presses.
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.new_press_mask == '0) ||
                    (out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
                     out_data_o.out_blue == '0))
    else $error("result mixes press mask and color");

endmodule

bind button_led_hold_fade_engine blhf_checker u_blhf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[test/testbench.sv]
// Testbench for the button light hold-and-fade engine: timer predictor, scoreboard and drivers.
module testbench;

  localparam int LIGHTS      = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;

  // Predicts each result from a copy of the light timers and registers, then holds it
  // until the block delivers its result transaction.
  class fade_scoreboard;
    logic [blhf_pkg::MS_W-1:0]    hold_ms;
    logic [blhf_pkg::MS_W-1:0]    fadeout_ms;
    logic [blhf_pkg::MASK_W-1:0]  button_mask;
    logic                         anim_en;
    logic [blhf_pkg::TIMER_W-1:0] timer [LIGHTS];
    blhf_pkg::out_item_t          expected_q [$];
    int                           errors;
    int                           results_seen;

    function new();
      hold_ms      = blhf_pkg::MS_W'(1);
      fadeout_ms   = '0;
      button_mask  = '0;
      anim_en      = 1'b0;
      errors       = 0;
      results_seen = 0;
      foreach (timer[i]) timer[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Register write as the block applies it.
    function void write_reg(blhf_pkg::cfg_reg_e idx, logic [blhf_pkg::CFG_W-1:0] value);
      case (idx)
        blhf_pkg::REG_HOLD_MS: begin
          hold_ms = (value[blhf_pkg::MS_W-1:0] == '0) ? blhf_pkg::MS_W'(1)
                                                     : value[blhf_pkg::MS_W-1:0];
        end
        blhf_pkg::REG_FADEOUT_MS:  fadeout_ms = value[blhf_pkg::MS_W-1:0];
        blhf_pkg::REG_BUTTON_MASK: button_mask = value;
        blhf_pkg::REG_ANIM_EN:     anim_en = value[0];
        default: ;
      endcase
    endfunction

    // Exact integer blend of one color channel for the remaining time t.
    function logic [blhf_pkg::CHAN_W-1:0] blend(logic [blhf_pkg::CHAN_W-1:0] s,
                                                logic [blhf_pkg::CHAN_W-1:0] e,
                                                logic [blhf_pkg::TIMER_W-1:0] t);
      longint unsigned sv_w, ev_w, tv_w, fv_w, num;
      sv_w = 64'(s);
      ev_w = 64'(e);
      tv_w = 64'(t);
      fv_w = 64'(fadeout_ms);
      if (tv_w == 0) return e;
      if (tv_w > fv_w || fv_w == 0) return s;
      num = sv_w * tv_w + ev_w * (fv_w - tv_w);
      return blhf_pkg::CHAN_W'(num / fv_w);
    endfunction

    // Advances the timers for an accepted transaction and queues its expected result.
    function void note_input(blhf_pkg::in_item_t it);
      blhf_pkg::out_item_t          r;
      logic [blhf_pkg::TIMER_W-1:0] reload;
      logic [blhf_pkg::TIMER_W-1:0] t;
      logic [blhf_pkg::TIMER_W-1:0] el;
      r = '0;
      reload = {1'b0, hold_ms} + {1'b0, fadeout_ms};
      el = {1'b0, it.elapsed_ms};
      if (it.kind == blhf_pkg::KIND_FRAME) begin
        if (anim_en) begin
          for (int i = 0; i < LIGHTS; i++) begin
            if (button_mask[i]) begin
              if (it.pressed_mask[i]) begin
                if (timer[i] == '0) r.new_press_mask[i] = 1'b1;
                timer[i] = reload;
              end else if (timer[i] != '0) begin
                if (timer[i] > el) timer[i] = timer[i] - el;
                else timer[i] = '0;
              end
            end
          end
        end
      end else begin
        t = timer[it.light_index];
        r.out_red   = blend(it.start_red, it.end_red, t);
        r.out_green = blend(it.start_green, it.end_green, t);
        r.out_blue  = blend(it.start_blue, it.end_blue, t);
      end
      expected_q = {expected_q, r};
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(blhf_pkg::out_item_t got);
      blhf_pkg::out_item_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: unexpected, mask %h rgb %h %h %h", results_seen,
                   got.new_press_mask, got.out_red, got.out_green, got.out_blue);
        return;
      end
      exp = expected_q.pop_front();
      if (got.new_press_mask !== exp.new_press_mask || got.out_red !== exp.out_red ||
          got.out_green !== exp.out_green || got.out_blue !== exp.out_blue) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected mask %h rgb %h %h %h, got mask %h rgb %h %h %h",
                   results_seen, exp.new_press_mask, exp.out_red, exp.out_green,
                   exp.out_blue, got.new_press_mask, got.out_red, got.out_green,
                   got.out_blue);
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  blhf_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  blhf_pkg::out_item_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [blhf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [blhf_pkg::CFG_W-1:0]     cfg_data = '0;

  fade_scoreboard sb = new();

  int tx_max_gap    = 12;
  int rx_max_stall  = 12;
  bit long_hold_req = 1'b0;
  int cycles        = 0;
  int cur_hold      = 1;
  int cur_fade      = 0;

  button_led_hold_fade_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("button_led_hold_fade_engine: mismatch");
      $finish;
    end
  end

  // Result transactions are taken between edges, where all signals are settled.
  always @(negedge clk_i) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: stalls a random number of cycles before each result, once for a long stretch.
  initial begin : receiver
    int   n;
    logic got;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        n = 400;
        long_hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, rx_max_stall);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk_i);
        got = out_valid;
        @(posedge clk_i);
      end while (!got);
    end
  end

  // Offers one input transaction after a random gap and notes it once accepted.
  task automatic send_item(input blhf_pkg::in_item_t it);
    int   gap;
    logic taken;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (!in_stall) begin
        taken = 1'b1;
        sb.note_input(it);
      end
      @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input blhf_pkg::cfg_reg_e idx,
                           input logic [blhf_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  // Writes all registers while the block is idle; unused upper bits carry noise.
  task automatic set_config(input int hold, input int fade, input logic [31:0] mask,
                            input bit anim);
    wait_drained();
    write_reg(blhf_pkg::REG_HOLD_MS,
              ($urandom & 32'hFFFF_0000) | blhf_pkg::CFG_W'(hold & 16'hFFFF));
    write_reg(blhf_pkg::REG_FADEOUT_MS,
              ($urandom & 32'hFFFF_0000) | blhf_pkg::CFG_W'(fade & 16'hFFFF));
    write_reg(blhf_pkg::REG_BUTTON_MASK, mask);
    write_reg(blhf_pkg::REG_ANIM_EN,
              ($urandom & 32'hFFFF_FFFE) | blhf_pkg::CFG_W'(anim));
    cfg_we   <= 1'b0;
    cur_hold = ((hold & 16'hFFFF) == 0) ? 1 : (hold & 16'hFFFF);
    cur_fade = fade & 16'hFFFF;
  endtask

  function automatic blhf_pkg::in_item_t random_item();
    blhf_pkg::in_item_t it;
    it.kind         = blhf_pkg::item_kind_e'($urandom_range(0, 1));
    it.pressed_mask = $urandom;
    it.elapsed_ms   = blhf_pkg::MS_W'($urandom);
    it.light_index  = blhf_pkg::IDX_W'($urandom);
    it.start_red    = blhf_pkg::CHAN_W'($urandom);
    it.start_green  = blhf_pkg::CHAN_W'($urandom);
    it.start_blue   = blhf_pkg::CHAN_W'($urandom);
    it.end_red      = blhf_pkg::CHAN_W'($urandom);
    it.end_green    = blhf_pkg::CHAN_W'($urandom);
    it.end_blue     = blhf_pkg::CHAN_W'($urandom);
    return it;
  endfunction

  function automatic blhf_pkg::in_item_t frame_item(logic [31:0] pressed,
                                                    logic [15:0] elapsed);
    blhf_pkg::in_item_t it;
    it = random_item();
    it.kind         = blhf_pkg::KIND_FRAME;
    it.pressed_mask = pressed;
    it.elapsed_ms   = elapsed;
    return it;
  endfunction

  function automatic blhf_pkg::in_item_t query_item(logic [4:0] light,
                                                    logic [23:0] start_rgb,
                                                    logic [23:0] end_rgb);
    blhf_pkg::in_item_t it;
    it = random_item();
    it.kind = blhf_pkg::KIND_QUERY;
    it.light_index = light;
    {it.start_red, it.start_green, it.start_blue} = start_rgb;
    {it.end_red, it.end_green, it.end_blue} = end_rgb;
    return it;
  endfunction

  // Frames mostly release buttons and step time inside the hold-plus-fade span,
  // so that timers spend many frames in the fade.
  function automatic blhf_pkg::in_item_t shaped_item();
    blhf_pkg::in_item_t it;
    int                 span;
    it = random_item();
    if (it.kind == blhf_pkg::KIND_FRAME) begin
      span = cur_hold + cur_fade;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: it.pressed_mask = '0;
        5, 6, 7:       it.pressed_mask = $urandom & $urandom & $urandom;
        8:             it.pressed_mask = $urandom;
        default:       it.pressed_mask = '1;
      endcase
      case ($urandom_range(0, 9))
        0:       it.elapsed_ms = '0;
        1:       it.elapsed_ms = blhf_pkg::MS_W'($urandom);
        default: it.elapsed_ms = blhf_pkg::MS_W'($urandom_range(0, span / 6 + 1));
      endcase
    end
    return it;
  endfunction

  // Main sequence: reset, directed transactions, then randomized phases.
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // With reset settings animation is off: frames report nothing, queries see idle timers.
    send_item(frame_item('1, '1));
    send_item(query_item(5'd5, 24'hFFFFFF, 24'h123456));

    // Zero hold time stores one; all lights are buttons.
    set_config(0, 10, '1, 1'b1);
    send_item(frame_item('1, '0));
    send_item(query_item(5'd0, 24'hFFFFFF, 24'h000000));
    send_item(frame_item('0, 16'd1));
    send_item(query_item(5'd31, 24'h000000, 24'hFFFFFF));
    send_item(frame_item('0, 16'd3));
    send_item(query_item(5'd7, 24'hFFFFFF, 24'h000000));
    send_item(query_item(5'd8, 24'h000000, 24'hFFFFFF));
    send_item(frame_item(32'hAAAA_AAAA, 16'd2));
    send_item(query_item(5'd2, 24'hFF00FF, 24'h00FF00));
    send_item(query_item(5'd1, 24'h80FF01, 24'h7F00FE));
    send_item(frame_item('0, '1));
    send_item(query_item(5'd3, 24'hFFFFFF, 24'h000000));
    send_item(frame_item(32'h8000_0001, '0));
    send_item(query_item(5'd31, 24'hA5C3E7, 24'h5A3C18));

    // Only the lower lights are buttons; a fade of zero switches colors straight from start to end.
    set_config(65535, 0, 32'h0000_FFFF, 1'b1);
    send_item(frame_item('1, 16'd100));
    send_item(query_item(5'd4, 24'h112233, 24'hFFEEDD));
    send_item(query_item(5'd20, 24'h112233, 24'hFFEEDD));
    send_item(frame_item(32'h5555_5555, '1));
    send_item(query_item(5'd15, 24'h000000, 24'hFFFFFF));

    for (int p = 0; p < PHASES; p++) begin
      tx_max_gap   = (p % 3 == 2) ? 0 : 12;
      rx_max_stall = (p % 4 == 3) ? 0 : 12;
      case (p)
        0:       set_config(0, 0, '1, 1'b1);
        1:       set_config(3, 20, $urandom, 1'b1);
        2:       set_config(65535, 65535, '1, 1'b1);
        3:       set_config(1, 65535, $urandom, 1'b1);
        4:       set_config($urandom_range(1, 300), $urandom_range(1, 500), $urandom, 1'b0);
        5:       set_config(100, 1, '1, 1'b1);
        6:       set_config(40, 300, '0, 1'b1);
        7:       set_config(50, 200, '1, 1'b1);
        default: set_config($urandom_range(1, 500), $urandom_range(0, 1000), $urandom, 1'b1);
      endcase
      // The receiver holds off while the sender keeps offering back to back.
      if (p == 7) begin
        tx_max_gap    = 0;
        long_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
        send_item(shaped_item());
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("button_led_hold_fade_engine: match");
    end else begin
      $display("button_led_hold_fade_engine: mismatch");
    end
    $finish;
  end

endmodule
